/* design/wavhc_pkg.sv */
// Shared types, constants and a helper function for the WAV header checker.
`default_nettype none
package wavhc_pkg;

	localparam int CNT_W = 33;
	localparam logic [CNT_W-1:0] HDR_BYTES = 33'd44;
	localparam logic [CNT_W-1:0] RIFF_HDR = 33'd8;

	localparam logic [31:0] TAG_RIFF = "RIFF";
	localparam logic [31:0] TAG_WAVE = "WAVE";
	localparam logic [31:0] TAG_FMT = "fmt ";
	localparam logic [31:0] TAG_DATA = "data";

	localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
	localparam logic [15:0] FORMAT_PCM = 16'd1;
	localparam logic signed [15:0] MAX_CHANNELS = 16'sd2;
	localparam logic [31:0] SIZE_GAP = 32'd20;

	typedef enum logic [3:0] {
		ERR_NONE      = 4'd0,
		ERR_RIFF      = 4'd1,
		ERR_WAVE      = 4'd2,
		ERR_FMT       = 4'd3,
		ERR_DATA      = 4'd4,
		ERR_FMT_SIZE  = 4'd5,
		ERR_FORMAT    = 4'd6,
		ERR_CHANNELS  = 4'd7,
		ERR_SIZES     = 4'd8,
		ERR_LENGTH    = 4'd9,
		ERR_TRUNCATED = 4'd10
	} err_code_t;

	typedef struct packed {
		logic [31:0] riff_size;
		logic [31:0] fmt_size;
		logic [15:0] format_code;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
		logic [3:0]  tag_err;
	} hdr_fields_t;

	// Expected character of a four-character tag; lane 0 is the first byte in the file.
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] lane);
		tag_byte = tag[{~lane, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

/* design/wavhc_verdict.sv */
// Verdict logic: turns a captured header and byte count into an error code.
`default_nettype none
module wavhc_verdict (
	input  wire wavhc_pkg::hdr_fields_t       hdr,
	input  wire logic [wavhc_pkg::CNT_W-1:0] byte_count,
	output wavhc_pkg::err_code_t              code
);

	logic [31:0] size_gap;
	logic [wavhc_pkg::CNT_W-1:0] expected_len;

	assign size_gap = hdr.riff_size - hdr.fmt_size - hdr.data_size;
	assign expected_len = {1'b0, hdr.riff_size} + wavhc_pkg::RIFF_HDR;

	// Later checks override earlier ones; length is checked only if all pass.
	always_comb begin
		code = wavhc_pkg::ERR_NONE;
		if (byte_count < wavhc_pkg::HDR_BYTES) begin
			code = wavhc_pkg::ERR_TRUNCATED;
		end else begin
			if (hdr.tag_err[0]) code = wavhc_pkg::ERR_RIFF;
			if (hdr.tag_err[1]) code = wavhc_pkg::ERR_WAVE;
			if (hdr.tag_err[2]) code = wavhc_pkg::ERR_FMT;
			if (hdr.tag_err[3]) code = wavhc_pkg::ERR_DATA;
			if (hdr.fmt_size != wavhc_pkg::FMT_SIZE_PCM) code = wavhc_pkg::ERR_FMT_SIZE;
			if (hdr.format_code != wavhc_pkg::FORMAT_PCM) code = wavhc_pkg::ERR_FORMAT;
			if ($signed(hdr.channels) > wavhc_pkg::MAX_CHANNELS) code = wavhc_pkg::ERR_CHANNELS;
			if (size_gap != wavhc_pkg::SIZE_GAP) code = wavhc_pkg::ERR_SIZES;
			if (code == wavhc_pkg::ERR_NONE && byte_count != expected_len) begin
				code = wavhc_pkg::ERR_LENGTH;
			end
		end
	end

endmodule
`default_nettype wire

/* design/wav_header_checker.sv */
// Top level of the WAV header checker: byte capture, pipeline and result register.
`default_nettype none
// Takes a WAV file one byte per beat, in file order, with last_byte set on the final beat,
// and gives one result beat per file carrying the verdict and the header fields. A byte
// is accepted every cycle while the result register is free or being emptied; the result
// for a file passes the input register, the capture stage and the verdict register after
// its last beat is accepted. Header and byte count clear after each file, so the next file
// may follow in the very next cycle. A held result stalls the whole pipeline and in_ready.
module wav_header_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    header_ok,
	output logic [3:0]              error_code,
	output logic signed [15:0]      channel_count,
	output logic [31:0]             sample_rate,
	output logic [31:0]             byte_rate,
	output logic [15:0]             block_align,
	output logic [15:0]             bits_per_sample,
	output logic [31:0]             data_size
);

	logic                               adv;
	logic                               valid_s1;
	logic                               last_s1;
	logic [7:0]                         byte_s1;
	wavhc_pkg::hdr_fields_t             hdr_q;
	wavhc_pkg::hdr_fields_t             hdr_d;
	logic [wavhc_pkg::CNT_W-1:0]        count_q;
	logic [wavhc_pkg::CNT_W-1:0]        count_d;
	logic [5:0]                         pos;
	logic                               valid_s2;
	wavhc_pkg::hdr_fields_t             hdr_s2;
	logic [wavhc_pkg::CNT_W-1:0]        count_s2;
	wavhc_pkg::err_code_t               code;
	logic                               out_valid_q;
	logic [3:0]                         code_q;
	wavhc_pkg::hdr_fields_t             hdr_out_q;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign pos = count_q[5:0];

	// Each header byte lands in its lane; all 32-bit fields and tags start on a multiple of four.
	always_comb begin
		hdr_d = hdr_q;
		count_d = (count_q != '1) ? count_q + 1'b1 : count_q;
		if (count_q < wavhc_pkg::HDR_BYTES) begin
			case (pos) inside
				[6'd0:6'd3]: begin
					if (byte_s1 != wavhc_pkg::tag_byte(wavhc_pkg::TAG_RIFF, pos[1:0]))
						hdr_d.tag_err[0] = 1'b1;
				end
				[6'd4:6'd7]:   hdr_d.riff_size[{pos[1:0], 3'b000} +: 8] = byte_s1;
				[6'd8:6'd11]: begin
					if (byte_s1 != wavhc_pkg::tag_byte(wavhc_pkg::TAG_WAVE, pos[1:0]))
						hdr_d.tag_err[1] = 1'b1;
				end
				[6'd12:6'd15]: begin
					if (byte_s1 != wavhc_pkg::tag_byte(wavhc_pkg::TAG_FMT, pos[1:0]))
						hdr_d.tag_err[2] = 1'b1;
				end
				[6'd16:6'd19]: hdr_d.fmt_size[{pos[1:0], 3'b000} +: 8] = byte_s1;
				[6'd20:6'd21]: hdr_d.format_code[{pos[0], 3'b000} +: 8] = byte_s1;
				[6'd22:6'd23]: hdr_d.channels[{pos[0], 3'b000} +: 8] = byte_s1;
				[6'd24:6'd27]: hdr_d.rate[{pos[1:0], 3'b000} +: 8] = byte_s1;
				[6'd28:6'd31]: hdr_d.byte_rate[{pos[1:0], 3'b000} +: 8] = byte_s1;
				[6'd32:6'd33]: hdr_d.block_align[{pos[0], 3'b000} +: 8] = byte_s1;
				[6'd34:6'd35]: hdr_d.sample_bits[{pos[0], 3'b000} +: 8] = byte_s1;
				[6'd36:6'd39]: begin
					if (byte_s1 != wavhc_pkg::tag_byte(wavhc_pkg::TAG_DATA, pos[1:0]))
						hdr_d.tag_err[3] = 1'b1;
				end
				[6'd40:6'd43]: hdr_d.data_size[{pos[1:0], 3'b000} +: 8] = byte_s1;
				default: ;
			endcase
		end
	end

	wavhc_verdict u_verdict (
		.hdr        (hdr_s2),
		.byte_count (count_s2),
		.code       (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			hdr_q <= '0;
			count_q <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && last_s1;
			out_valid_q <= valid_s2;
			if (valid_s1) begin
				// The final beat hands the header on and leaves clean state for the next file.
				if (last_s1) begin
					hdr_q <= '0;
					count_q <= '0;
				end else begin
					hdr_q <= hdr_d;
					count_q <= count_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				byte_s1 <= data_byte;
				last_s1 <= last_byte;
			end
			if (valid_s1 && last_s1) begin
				hdr_s2 <= hdr_d;
				count_s2 <= count_d;
			end
			if (valid_s2) begin
				code_q <= code;
				hdr_out_q <= hdr_s2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign error_code = code_q;
	assign header_ok = (code_q == wavhc_pkg::ERR_NONE);
	assign channel_count = $signed(hdr_out_q.channels);
	assign sample_rate = hdr_out_q.rate;
	assign byte_rate = hdr_out_q.byte_rate;
	assign block_align = hdr_out_q.block_align;
	assign bits_per_sample = hdr_out_q.sample_bits;
	assign data_size = hdr_out_q.data_size;

endmodule
`default_nettype wire

/* design/wavhc_checker.sv */
// Port-level assertions for the WAV header checker, bound to the top level.
`default_nettype none
module wavhc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               header_ok,
	input wire logic [3:0]         error_code,
	input wire logic signed [15:0] channel_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_code))
		else $error("result beat changed while stalled");

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_ok == (error_code == wavhc_pkg::ERR_NONE))
		else $error("header_ok disagrees with error_code");

	a_ok_channels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_ok |-> channel_count <= wavhc_pkg::MAX_CHANNELS)
		else $error("passing header with too many channels");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result beat held");

endmodule

bind wav_header_checker wavhc_checker u_wavhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.header_ok     (header_ok),
	.error_code    (error_code),
	.channel_count (channel_count)
);
`default_nettype wire
